[sv/assert_macros.svh]
// ---------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion wrappers for the rtl files
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every rising clock edge outside reset
`define SMM_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// condition must never be true outside reset
`define SMM_NEVER(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

[sv/smm_pkg.sv]
// ---------------------------------------------------------------------------
// smm_pkg
// types and constants of the square matrix multiply block
// ---------------------------------------------------------------------------
package smm_pkg;

   localparam int MAX_DIM    = 8;
   localparam int DIM_BITS   = $clog2(MAX_DIM);
   localparam int ADDR_BITS  = 2 * DIM_BITS;
   localparam int DEPTH      = MAX_DIM * MAX_DIM;
   localparam int SIZE_BITS  = 4;
   localparam int WORD_BITS  = 16;
   localparam int MUL_BITS   = 2 * WORD_BITS;
   localparam int PROD_BITS  = 35;

   typedef logic [1:0]                  kind_type;
   typedef logic [2:0]                  index_type;
   typedef logic [SIZE_BITS-1:0]        size_type;
   typedef logic signed [WORD_BITS-1:0] word_type;
   typedef logic signed [MUL_BITS-1:0]  mul_type;
   typedef logic signed [PROD_BITS-1:0] prod_type;
   typedef logic [ADDR_BITS-1:0]        addr_type;

   localparam kind_type KIND_LOAD_A  = 2'd0;
   localparam kind_type KIND_LOAD_B  = 2'd1;
   localparam kind_type KIND_COMPUTE = 2'd2;

   localparam size_type SIZE_RESET = 4'd8;
   localparam size_type SIZE_MAX   = size_type'(MAX_DIM);

endpackage

[sv/smm_if.sv]
// ---------------------------------------------------------------------------
// smm request and response channels
// valid/ready channels carrying requests into and results out of the block
// ---------------------------------------------------------------------------
interface smm_req_if;
   import smm_pkg::*;

   logic      valid;
   logic      ready;
   kind_type  kind;
   index_type row;
   index_type col;
   word_type  value;

   modport source (output valid, output kind, output row, output col, output value,
                   input ready);
   modport sink   (input valid, input kind, input row, input col, input value,
                   output ready);
endinterface

interface smm_rsp_if;
   import smm_pkg::*;

   logic      valid;
   logic      ready;
   index_type out_row;
   index_type out_col;
   prod_type  product;
   logic      out_of_range;

   modport source (output valid, output out_row, output out_col, output product,
                   output out_of_range, input ready);
   modport sink   (input valid, input out_row, input out_col, input product,
                   input out_of_range, output ready);
endinterface

[sv/square_matrix_multiply.sv]
// ---------------------------------------------------------------------------
// square_matrix_multiply
// two stored signed q8.8 matrices, one product element per compute request
// ---------------------------------------------------------------------------
// usage:
//   req carries load and compute requests (valid/ready). a load writes one
//   element of the first or second matrix (nothing if out of range) and
//   returns nothing; loads are taken one per cycle while the block is idle.
//   a compute request names row and column; rsp returns the exact q.16 dot
//   product over the size in use, or zero with out_of_range set.
//   csr_wr_en/csr_wr_data set the size in use; write only while idle.
// sequencing:
//   a compute walks one k index per cycle through a single multiply-
//   accumulate fed by two synchronous memories, up to the size in use
//   (max 8); the result is registered once the last product is summed,
//   and the next request is taken only then, so computes never overlap.
//   an out of range compute skips the walk and goes to the result register.
// reset:
//   synchronous, clears the sequencer and output valid; size returns to 8.
//   matrix contents are undefined until written.
// stall:
//   a result waiting on rsp holds its value; a finished compute waits in
//   the sequencer until the output register is free.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module square_matrix_multiply (
   input  logic               clock,
   input  logic               reset,
   smm_req_if.sink            req,
   smm_rsp_if.source          rsp,
   input  logic               csr_wr_en,
   input  smm_pkg::size_type  csr_wr_data
);
   import smm_pkg::*;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_RUN  = 2'd1;
   localparam logic [1:0] ST_WAIT = 2'd2;

   word_type  first_mem  [DEPTH];
   word_type  second_mem [DEPTH];

   size_type  size_ff, size_in;
   logic [1:0] state_ff, state_in;
   index_type k_ff, k_in;
   index_type row_ff, row_in;
   index_type col_ff, col_in;
   logic      bad_ff, bad_in;
   logic      rd_valid_ff, rd_valid_in;
   logic      mul_valid_ff, mul_valid_in;
   word_type  rd_a_ff, rd_b_ff;
   mul_type   mul_ff, mul_in;
   prod_type  acc_ff, acc_in;

   logic      rsp_valid_ff, rsp_valid_in;
   index_type rsp_row_ff, rsp_row_in;
   index_type rsp_col_ff, rsp_col_in;
   prod_type  rsp_prod_ff, rsp_prod_in;
   logic      rsp_oor_ff, rsp_oor_in;

   size_type  size_use;
   logic      req_fire;
   logic      req_bad;
   logic      we_a, we_b;
   addr_type  wr_addr, rd_addr_a, rd_addr_b;
   logic      out_free;

   // size in use and request decode
   always_comb begin
      size_use  = (size_ff > SIZE_MAX) ? SIZE_MAX : size_ff;
      req_fire  = req.valid && req.ready;
      req_bad   = ({1'b0, req.row} >= size_use) || ({1'b0, req.col} >= size_use);
      we_a      = req_fire && (req.kind == KIND_LOAD_A) && !req_bad;
      we_b      = req_fire && (req.kind == KIND_LOAD_B) && !req_bad;
      wr_addr   = {req.row, req.col};
      rd_addr_a = {row_ff, k_ff};
      rd_addr_b = {k_ff, col_ff};
      out_free  = !rsp_valid_ff || rsp.ready;
   end

   assign req.ready = (state_ff == ST_IDLE);

   // matrix memories, registered read
   always_ff @(posedge clock) begin
      if (we_a) begin
         first_mem[wr_addr] <= req.value;
      end
      if (we_b) begin
         second_mem[wr_addr] <= req.value;
      end
      rd_a_ff <= first_mem[rd_addr_a];
      rd_b_ff <= second_mem[rd_addr_b];
   end

   // sequencer and multiply-accumulate
   always_comb begin
      size_in      = csr_wr_en ? csr_wr_data : size_ff;
      state_in     = state_ff;
      k_in         = k_ff;
      row_in       = row_ff;
      col_in       = col_ff;
      bad_in       = bad_ff;
      rd_valid_in  = 1'b0;
      mul_in       = rd_a_ff * rd_b_ff;
      mul_valid_in = rd_valid_ff;
      acc_in       = mul_valid_ff ? acc_ff + prod_type'(mul_ff) : acc_ff;
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      rsp_row_in   = rsp_row_ff;
      rsp_col_in   = rsp_col_ff;
      rsp_prod_in  = rsp_prod_ff;
      rsp_oor_in   = rsp_oor_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire && (req.kind == KIND_COMPUTE)) begin
               row_in   = req.row;
               col_in   = req.col;
               bad_in   = req_bad;
               k_in     = '0;
               acc_in   = '0;
               state_in = req_bad ? ST_WAIT : ST_RUN;
            end
         end
         ST_RUN: begin
            rd_valid_in = 1'b1;
            k_in        = k_ff + 3'd1;
            if ({1'b0, k_ff} == size_use - 4'd1) begin
               state_in = ST_WAIT;
            end
         end
         ST_WAIT: begin
            if (!rd_valid_ff && !mul_valid_ff && out_free) begin
               rsp_valid_in = 1'b1;
               rsp_row_in   = row_ff;
               rsp_col_in   = col_ff;
               rsp_prod_in  = bad_ff ? '0 : acc_ff;
               rsp_oor_in   = bad_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff      <= SIZE_RESET;
         state_ff     <= ST_IDLE;
         rd_valid_ff  <= 1'b0;
         mul_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         size_ff      <= size_in;
         state_ff     <= state_in;
         rd_valid_ff  <= rd_valid_in;
         mul_valid_ff <= mul_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      k_ff        <= k_in;
      row_ff      <= row_in;
      col_ff      <= col_in;
      bad_ff      <= bad_in;
      mul_ff      <= mul_in;
      acc_ff      <= acc_in;
      rsp_row_ff  <= rsp_row_in;
      rsp_col_ff  <= rsp_col_in;
      rsp_prod_ff <= rsp_prod_in;
      rsp_oor_ff  <= rsp_oor_in;
   end

   assign rsp.valid        = rsp_valid_ff;
   assign rsp.out_row      = rsp_row_ff;
   assign rsp.out_col      = rsp_col_ff;
   assign rsp.product      = rsp_prod_ff;
   assign rsp.out_of_range = rsp_oor_ff;

   `SMM_ASSERT(a_oor_zero, clock, reset, (rsp.valid && rsp.out_of_range) |-> (rsp.product == '0), "out of range result with nonzero product")
   `SMM_ASSERT(a_idle_drained, clock, reset, (state_ff == ST_IDLE) |-> (!rd_valid_ff && !mul_valid_ff), "mac pipeline busy while idle")
   `SMM_ASSERT(a_compute_busy, clock, reset, (req_fire && (req.kind == KIND_COMPUTE)) |=> (state_ff != ST_IDLE), "compute request did not start sequencer")
   `SMM_NEVER(a_no_result_overwrite, clock, reset, (rsp_valid_ff && !rsp.ready && (state_ff == ST_WAIT) && !rd_valid_ff && !mul_valid_ff && rsp_valid_in && (rsp_row_in != rsp_row_ff)), "pending result overwritten")

endmodule
